[src/bas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg: shared types and constants for the button auto-repeat scanner
// Event, button and speed codes, reset values and the result beat layout.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int TICK_W      = 16;
    localparam int HOLD_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0] SHORT_INTERVAL_RESET = 16'd24;
    localparam logic [TICK_W-1:0] LONG_INTERVAL_RESET  = 16'd220;

    // hold count bands, tested after the increment
    localparam logic [HOLD_W-1:0] HOLD_FASTER_ABOVE = 8'd24;
    localparam logic [HOLD_W-1:0] HOLD_LONG_ABOVE   = 8'd5;
    localparam logic [HOLD_W-1:0] HOLD_FAST_ABOVE   = 8'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT_INTERVAL = 2'd0,
        REG_LONG_INTERVAL  = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EV_NOT_YET    = 3'd0,
        EV_NONE       = 3'd1,
        EV_UP         = 3'd2,
        EV_DOWN       = 3'd3,
        EV_ALARM      = 3'd4,
        EV_UP_REL     = 3'd5,
        EV_DOWN_REL   = 3'd6,
        EV_ALARM_REL  = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_UP    = 2'd1,
        BTN_DOWN  = 2'd2,
        BTN_ALARM = 2'd3
    } button_t;

    typedef enum logic [1:0] {
        SPD_NO_CHANGE = 2'd0,
        SPD_NORMAL    = 2'd1,
        SPD_FAST      = 2'd2,
        SPD_FASTER    = 2'd3
    } speed_t;

    typedef struct packed {
        event_t             event_code;
        logic [HOLD_W-1:0]  hold_count;
        speed_t             speed_command;
    } result_t;

endpackage

[src/bas_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_if: valid/ready channels of the button auto-repeat scanner
// Button level beats in, event beats out, register writes.
// ----------------------------------------------------------------------------
interface bas_btn_if;
    logic valid;
    logic ready;
    logic up_level;
    logic down_level;
    logic alarm_level;

    modport source (output valid, up_level, down_level, alarm_level, input ready);
    modport sink   (input valid, up_level, down_level, alarm_level, output ready);
endinterface

interface bas_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [7:0] hold_count;
    logic [1:0] speed_command;

    modport source (output valid, event_code, hold_count, speed_command, input ready);
    modport sink   (input valid, event_code, hold_count, speed_command, output ready);
endinterface

interface bas_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/bas_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_core: tick counter, sampling and hold state
// Holds the interval registers and scanner state, and works out the result
// of one tick beat from the current state and button levels.
// ----------------------------------------------------------------------------
module bas_core
    import bas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   up_level,
    input  logic                   down_level,
    input  logic                   alarm_level,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output result_t                result
);

    logic [TICK_W-1:0] short_interval_reg;
    logic [TICK_W-1:0] long_interval_reg;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic              long_selected_reg, long_selected_next;
    logic [HOLD_W-1:0] press_count_reg, press_count_next;
    button_t           held_button_reg, held_button_next;

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] interval;
    logic [HOLD_W-1:0] press_inc;
    logic              sample;
    button_t           pressed;

    always_comb
    begin
        tick_inc  = (tick_count_reg == '1) ? tick_count_reg : tick_count_reg + 1'b1;
        press_inc = (press_count_reg == '1) ? press_count_reg : press_count_reg + 1'b1;
        interval  = long_selected_reg ? long_interval_reg : short_interval_reg;
        sample    = (tick_inc >= interval);

        if (!up_level)
            pressed = BTN_UP;
        else if (!down_level)
            pressed = BTN_DOWN;
        else if (!alarm_level)
            pressed = BTN_ALARM;
        else
            pressed = BTN_NONE;
    end

    always_comb
    begin
        tick_count_next     = tick_inc;
        long_selected_next  = long_selected_reg;
        press_count_next    = press_count_reg;
        held_button_next    = held_button_reg;
        result.event_code    = EV_NOT_YET;
        result.hold_count    = press_count_reg;
        result.speed_command = SPD_NO_CHANGE;

        if (sample)
        begin
            tick_count_next = '0;
            if (pressed == BTN_NONE)
            begin
                result.event_code = EV_NONE;
                if (held_button_reg != BTN_NONE)
                begin
                    // release: report which button let go, then drop to idle
                    case (held_button_reg)
                        BTN_UP:    result.event_code = EV_UP_REL;
                        BTN_DOWN:  result.event_code = EV_DOWN_REL;
                        BTN_ALARM: result.event_code = EV_ALARM_REL;
                        default:   result.event_code = EV_NONE;
                    endcase
                    held_button_next     = BTN_NONE;
                    press_count_next     = '0;
                    long_selected_next   = 1'b0;
                    result.speed_command = SPD_NORMAL;
                end
            end
            else
            begin
                press_count_next = press_inc;
                if (press_inc > HOLD_FASTER_ABOVE)
                begin
                    long_selected_next   = 1'b0;
                    result.speed_command = SPD_FASTER;
                end
                else if (press_inc > HOLD_LONG_ABOVE)
                    long_selected_next = 1'b1;
                else if (press_inc > HOLD_FAST_ABOVE)
                    result.speed_command = SPD_FAST;

                case (pressed)
                    BTN_UP:    result.event_code = EV_UP;
                    BTN_DOWN:  result.event_code = EV_DOWN;
                    BTN_ALARM: result.event_code = EV_ALARM;
                    default:   result.event_code = EV_NONE;
                endcase
                held_button_next = pressed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_interval_reg <= SHORT_INTERVAL_RESET;
            long_interval_reg  <= LONG_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SHORT_INTERVAL: short_interval_reg <= cfg_data;
                REG_LONG_INTERVAL:  long_interval_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            long_selected_reg <= 1'b0;
            press_count_reg   <= '0;
            held_button_reg   <= BTN_NONE;
        end
        else if (step)
        begin
            tick_count_reg    <= tick_count_next;
            long_selected_reg <= long_selected_next;
            press_count_reg   <= press_count_next;
            held_button_reg   <= held_button_next;
        end
    end

endmodule

[src/bas_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_skid: two-entry result buffer
// Output register plus one skid entry, so a new beat is taken while the
// current result still waits for the receiver.
// ----------------------------------------------------------------------------
module bas_skid
    import bas_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid entry goes first; no push can arrive while it is full
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
            skid_data_reg <= push_data;
    end

endmodule

[src/button_autorepeat_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_autorepeat_scanner: debounced three-button scanner with auto-repeat
// Usage:
//   btn  - one beat per timer tick with the active-low up, down and alarm
//          levels. Every beat yields exactly one evt beat.
//   evt  - event_code, hold_count (press count before the tick) and
//          speed_command. Code 0 means the sample interval has not elapsed.
//   cfg  - register writes: index 0 short_interval, index 1 long_interval;
//          other indexes are ignored. Write only while no beat is in flight.
// Timing: one tick beat per clock while btn.ready is high; each result is
//   registered in the output register, or in the skid entry on a stall. All
//   work is one pass of compare and counter logic from the state registers.
// Stall: a result register plus one skid entry; btn.ready drops only when
//   both hold results the receiver has not taken.
// Reset: intervals return to 24 and 220, counters and the held button clear,
//   and the output buffer empties. cfg.ready is always high.
// ----------------------------------------------------------------------------
module button_autorepeat_scanner
    import bas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bas_btn_if.sink   btn,
    bas_evt_if.source evt,
    bas_cfg_if.sink   cfg
);

    logic    accept;
    logic    push_ready;
    result_t step_result;
    result_t out_data;

    assign btn.ready = push_ready;
    assign accept    = btn.valid && push_ready;
    assign cfg.ready = 1'b1;

    bas_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .up_level    (btn.up_level),
        .down_level  (btn.down_level),
        .alarm_level (btn.alarm_level),
        .cfg_write   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .result      (step_result)
    );

    bas_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (step_result),
        .push_ready (push_ready),
        .out_valid  (evt.valid),
        .out_ready  (evt.ready),
        .out_data   (out_data)
    );

    assign evt.event_code    = out_data.event_code;
    assign evt.hold_count    = out_data.hold_count;
    assign evt.speed_command = out_data.speed_command;

endmodule

[src/bas_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_checker: port-level checks for the button auto-repeat scanner
// Watches the btn and evt channels and flags broken results or flow.
// ----------------------------------------------------------------------------
module bas_checker
    import bas_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       btn_valid,
    input logic       btn_ready,
    input logic       evt_valid,
    input logic       evt_ready,
    input logic [2:0] event_code,
    input logic [7:0] hold_count,
    input logic [1:0] speed_command
);

    // a stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid)
        else $error("evt beat dropped while stalled");

    // a tick taken with the output empty shows on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        btn_valid && btn_ready && !evt_valid |=> evt_valid)
        else $error("result missing after accepted tick");

    // not yet and no-press results never command a speed change
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (event_code == EV_NOT_YET || event_code == EV_NONE)
        |-> speed_command == SPD_NO_CHANGE)
        else $error("speed command on an idle result");

    // faster speed only on a press whose hold count is at least HOLD_FASTER_ABOVE
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && speed_command == SPD_FASTER
        |-> (event_code == EV_UP || event_code == EV_DOWN || event_code == EV_ALARM)
            && hold_count >= HOLD_FASTER_ABOVE)
        else $error("faster speed without a long hold");

    // normal speed comes only with a release code
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && speed_command == SPD_NORMAL
        |-> (event_code == EV_UP_REL || event_code == EV_DOWN_REL
             || event_code == EV_ALARM_REL))
        else $error("normal speed without a release");

endmodule

bind button_autorepeat_scanner bas_checker u_bas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .btn_valid     (btn.valid),
    .btn_ready     (btn.ready),
    .evt_valid     (evt.valid),
    .evt_ready     (evt.ready),
    .event_code    (evt.event_code),
    .hold_count    (evt.hold_count),
    .speed_command (evt.speed_command)
);
